[design/srfr_pkg.sv]
// Package for the serial response frame receiver: frame layout, marker bytes,
// byte positions and result packing.
// No dependencies.
package srfr_pkg;

   localparam int unsigned FRAME_BYTES = 10;
   localparam int unsigned COUNT_W     = $clog2(FRAME_BYTES + 1);
   localparam int unsigned REQ_TDATA_W = 8;
   localparam int unsigned RSP_FIELD_W = 1 + 8 + 16;
   localparam int unsigned RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef logic [COUNT_W-1:0] count_type;

   localparam logic [7:0]  START_BYTE = 8'h7E;
   localparam logic [7:0]  END_BYTE   = 8'hEF;
   localparam logic [7:0]  VERSION_CONST = 8'hFF;
   localparam logic [7:0]  LENGTH_CONST  = 8'h06;
   localparam logic [15:0] SUM_SEED = 16'(VERSION_CONST) + 16'(LENGTH_CONST);

   localparam count_type POS_START    = count_type'(0);
   localparam count_type POS_COMMAND  = count_type'(3);
   localparam count_type POS_FEEDBACK = count_type'(4);
   localparam count_type POS_PARAM_HI = count_type'(5);
   localparam count_type POS_PARAM_LO = count_type'(6);
   localparam count_type POS_CHECK_HI = count_type'(7);
   localparam count_type POS_CHECK_LO = count_type'(8);
   localparam count_type POS_END      = count_type'(FRAME_BYTES - 1);

   localparam logic STATUS_VALID  = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

endpackage

[design/serial_response_frame_receiver_unit.sv]
// Serial response frame receiver: hunts for a start byte, gathers a ten-byte
// frame and reports its command and parameter or a reject status.
// Depends on srfr_pkg.
//
//  channel | dir | tdata fields (low bit up)                          | per
//  req_    | in  | rx_byte[7:0]                                       | byte
//  rsp_    | out | frame_status[0], frame_command[8:1],               | frame
//          |     | frame_parameter[24:9], zero[31:25]                 |
//
// One byte per cycle while req_tready is high; the checksum is a running
// 16-bit sum, one add per payload byte; the end byte closes it with one add
// and compare. A result appears in the cycle after the tenth byte of a frame.
// Reset (synchronous) returns to hunting and empties the result register.
// req_tready drops only while the end byte is due and a result still waits.
module serial_response_frame_receiver_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [srfr_pkg::REQ_TDATA_W-1:0]     req_tdata,   // rx_byte[7:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // frame_status[0], frame_command[8:1], frame_parameter[24:9], zero
   output logic [srfr_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   srfr_pkg::count_type count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  param_hi_ff, param_hi_in;
   logic [7:0]  param_lo_ff, param_lo_in;
   logic [7:0]  check_hi_ff, check_hi_in;
   logic [7:0]  check_lo_ff, check_lo_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        status_ff, status_in;
   logic [7:0]  rsp_command_ff, rsp_command_in;
   logic [15:0] rsp_param_ff, rsp_param_in;
   logic        req_fire;
   logic        emit;
   logic        frame_ok;
   logic [7:0]  rx_byte;
   logic [15:0] check_total;

   assign rx_byte     = req_tdata[7:0];
   assign req_tready  = !(count_ff == srfr_pkg::POS_END && rsp_valid_ff && !rsp_tready);
   assign req_fire    = req_tvalid && req_tready;
   assign check_total = sum_ff + {check_hi_ff, check_lo_ff};
   assign frame_ok    = (rx_byte == srfr_pkg::END_BYTE) && (check_total == 16'h0000);

   always_comb begin
      count_in    = count_ff;
      sum_in      = sum_ff;
      command_in  = command_ff;
      param_hi_in = param_hi_ff;
      param_lo_in = param_lo_ff;
      check_hi_in = check_hi_ff;
      check_lo_in = check_lo_ff;
      emit        = 1'b0;
      if (req_fire) begin
         if (count_ff == srfr_pkg::POS_START || count_ff > srfr_pkg::POS_END) begin
            // hunt: drop everything but the start byte
            sum_in   = srfr_pkg::SUM_SEED;
            count_in = (rx_byte == srfr_pkg::START_BYTE) ?
                       srfr_pkg::count_type'(1) : srfr_pkg::POS_START;
         end else begin
            count_in = srfr_pkg::count_type'(count_ff + 1'b1);
            case (count_ff)
               srfr_pkg::POS_COMMAND: begin
                  command_in = rx_byte;
                  sum_in     = sum_ff + {8'h00, rx_byte};
               end
               srfr_pkg::POS_FEEDBACK: begin
                  sum_in = sum_ff + {15'd0, (rx_byte != 8'h00)};
               end
               srfr_pkg::POS_PARAM_HI: begin
                  param_hi_in = rx_byte;
                  sum_in      = sum_ff + {8'h00, rx_byte};
               end
               srfr_pkg::POS_PARAM_LO: begin
                  param_lo_in = rx_byte;
                  sum_in      = sum_ff + {8'h00, rx_byte};
               end
               srfr_pkg::POS_CHECK_HI: begin
                  check_hi_in = rx_byte;
               end
               srfr_pkg::POS_CHECK_LO: begin
                  check_lo_in = rx_byte;
               end
               srfr_pkg::POS_END: begin
                  count_in = srfr_pkg::POS_START;
                  emit     = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      status_in      = status_ff;
      rsp_command_in = rsp_command_ff;
      rsp_param_in   = rsp_param_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (frame_ok) begin
            status_in      = srfr_pkg::STATUS_VALID;
            rsp_command_in = command_ff;
            rsp_param_in   = {param_hi_ff, param_lo_ff};
         end else begin
            status_in      = srfr_pkg::STATUS_REJECT;
            rsp_command_in = 8'h00;
            rsp_param_in   = 16'h0000;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= srfr_pkg::POS_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff         <= sum_in;
      command_ff     <= command_in;
      param_hi_ff    <= param_hi_in;
      param_lo_ff    <= param_lo_in;
      check_hi_ff    <= check_hi_in;
      check_lo_ff    <= check_lo_in;
      status_ff      <= status_in;
      rsp_command_ff <= rsp_command_in;
      rsp_param_ff   <= rsp_param_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = srfr_pkg::RSP_TDATA_W'({rsp_param_ff, rsp_command_ff, status_ff});

endmodule

[design/srfr_checker.sv]
// Port-level checker for the serial response frame receiver, with its bind.
// Depends on srfr_pkg and serial_response_frame_receiver_unit.
module srfr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [srfr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result present after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a waiting result");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] == srfr_pkg::STATUS_REJECT
      |-> rsp_tdata[srfr_pkg::RSP_TDATA_W-1:1] == '0)
      else $error("rejected transaction carries data");

endmodule

bind serial_response_frame_receiver_unit srfr_checker u_srfr_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 100ps
// Testbench for serial_response_frame_receiver_unit: streams bytes into the receiver
// and checks each frame result against a bit-accurate frame predictor in a scoreboard.
// Depends on srfr_pkg and the receiver RTL.
module testbench;

   typedef struct packed {
      logic        status;
      logic [7:0]  command;
      logic [15:0] param_word;
   } frame_result;

   class frame_scoreboard;
      int unsigned fill;
      logic [7:0]  held [srfr_pkg::FRAME_BYTES];
      frame_result pending [$];
      int unsigned failures;
      int unsigned checked;

      function new();
         fill = 0;
         failures = 0;
         checked = 0;
      endfunction

      static function logic [15:0] checksum_for(logic [7:0] cmd, logic [7:0] fb,
                                                logic [7:0] dh, logic [7:0] dl);
         logic [15:0] total;
         total = 16'(srfr_pkg::VERSION_CONST) + 16'(srfr_pkg::LENGTH_CONST) + 16'(cmd)
                 + 16'(fb != 8'h00) + 16'(dh) + 16'(dl);
         return 16'h0000 - total;
      endfunction

      function void note_byte(logic [7:0] b);
         frame_result r;
         logic [15:0] got;
         if (fill == 0) begin
            if (b == srfr_pkg::START_BYTE) begin
               held[0] = b;
               fill = 1;
            end
            return;
         end
         held[fill] = b;
         fill++;
         if (fill < srfr_pkg::FRAME_BYTES) return;
         fill = 0;
         got = {held[srfr_pkg::POS_CHECK_HI], held[srfr_pkg::POS_CHECK_LO]};
         if (held[srfr_pkg::POS_END] == srfr_pkg::END_BYTE &&
             got == checksum_for(held[srfr_pkg::POS_COMMAND], held[srfr_pkg::POS_FEEDBACK],
                                 held[srfr_pkg::POS_PARAM_HI],
                                 held[srfr_pkg::POS_PARAM_LO])) begin
            r.status     = srfr_pkg::STATUS_VALID;
            r.command    = held[srfr_pkg::POS_COMMAND];
            r.param_word = {held[srfr_pkg::POS_PARAM_HI], held[srfr_pkg::POS_PARAM_LO]};
         end else begin
            r.status     = srfr_pkg::STATUS_REJECT;
            r.command    = 8'h00;
            r.param_word = 16'h0000;
         end
         pending.push_back(r);
      endfunction

      function void check_frame(logic [srfr_pkg::RSP_TDATA_W-1:0] data);
         frame_result e;
         if (pending.size() == 0) begin
            $error("unexpected frame result tdata=%h", data);
            failures++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (data[0] !== e.status) begin
            $error("frame_status expected %0d got %0d", e.status, data[0]);
            failures++;
         end
         if (data[8:1] !== e.command) begin
            $error("frame_command expected %h got %h", e.command, data[8:1]);
            failures++;
         end
         if (data[24:9] !== e.param_word) begin
            $error("frame_parameter expected %h got %h", e.param_word, data[24:9]);
            failures++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [srfr_pkg::REQ_TDATA_W-1:0] req_tdata = '0;   // rx_byte[7:0]
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   // frame_status[0], frame_command[8:1], frame_parameter[24:9], zero
   logic [srfr_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   frame_scoreboard board = new();
   int unsigned burst_left = 0;
   int unsigned frame_bytes_sent = 0;

   serial_response_frame_receiver_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                 : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      board.note_byte(b);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] version, input logic [7:0] length,
                             input logic [7:0] cmd, input logic [7:0] fb,
                             input logic [7:0] dh, input logic [7:0] dl,
                             input logic [15:0] check_flip, input logic [7:0] end_byte);
      logic [15:0] chk;
      chk = frame_scoreboard::checksum_for(cmd, fb, dh, dl) ^ check_flip;
      send_byte(srfr_pkg::START_BYTE);
      send_byte(version);
      send_byte(length);
      send_byte(cmd);
      send_byte(fb);
      send_byte(dh);
      send_byte(dl);
      send_byte(chk[15:8]);
      send_byte(chk[7:0]);
      send_byte(end_byte);
      frame_bytes_sent += srfr_pkg::FRAME_BYTES;
   endtask

   task automatic send_random_frame();
      logic [7:0]  version, length, cmd, fb, end_byte;
      logic [15:0] flip;
      version  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : srfr_pkg::VERSION_CONST;
      length   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : srfr_pkg::LENGTH_CONST;
      cmd      = 8'($urandom);
      fb       = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
      flip     = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(1, 16'hFFFF)) : 16'h0000;
      end_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom) : srfr_pkg::END_BYTE;
      send_frame(version, length, cmd, fb, 8'($urandom), 8'($urandom), flip, end_byte);
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(srfr_pkg::START_BYTE, 8'hFF, 8'hFF, 8'h80, 8'hFF, 8'hFF, 16'h0000,
                 srfr_pkg::END_BYTE);
      send_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00);

      while (frame_bytes_sent < 650) begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         end
         send_random_frame();
      end
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (board.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      int unsigned cyc;
      int unsigned hold_left;
      int unsigned hold_mark;
      cyc = 0;
      hold_left = 0;
      hold_mark = 10;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_left == 0 && board.checked >= hold_mark) begin
            hold_left = $urandom_range(40, 80);
            hold_mark += 35;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            case ((cyc / 150) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= (cyc % 2) == 0;
               2: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= (cyc % 5) != 0;
            endcase
         end
         cyc++;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_frame(rsp_tdata);
   end

endmodule
